// File: hw/rtl/urlpd_pkg.sv
// Types, constants and hex digit helper shared by the URL percent decoder.
package urlpd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_FIRST    = 2'd1;
    localparam logic [1:0] PH_SECOND   = 2'd2;
    localparam logic [1:0] PH_RESERVED = 2'd3;

    localparam logic [7:0] PERCENT_CHAR = 8'h25;

    typedef struct packed {
        logic [1:0] escape_phase;
        logic [3:0] high_nibble;
        logic       first_digit_valid;
    } esc_state_t;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t h;
        h.is_digit = 1'b1;
        h.value    = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            h.value = 4'(b - 8'h41 + 8'd10);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            h.value = 4'(b - 8'h61 + 8'd10);
        end
        else
        begin
            h.is_digit = 1'b0;
        end
        return h;
    endfunction

endpackage

// File: hw/rtl/urlpd_step.sv
// Escape decode for one character: next escape state and optional decoded byte.
module urlpd_step (
    input  urlpd_pkg::esc_state_t state,
    input  urlpd_pkg::in_item_t   item,
    output urlpd_pkg::esc_state_t state_next,
    output logic                  emit,
    output urlpd_pkg::out_item_t  result
);

    urlpd_pkg::hex_digit_t hd;
    logic [3:0]            dval;

    assign hd   = urlpd_pkg::hex_decode(item.in_byte);
    assign dval = hd.is_digit ? hd.value : 4'd0;

    always_comb
    begin
        state_next      = '0;
        emit            = 1'b1;
        result.out_last = item.in_last;
        result.out_byte = item.in_byte;
        unique case (state.escape_phase)
            urlpd_pkg::PH_FIRST:
            begin
                result.out_byte = {4'd0, dval};
                if (!item.in_last)
                begin
                    emit                         = 1'b0;
                    state_next.escape_phase      = urlpd_pkg::PH_SECOND;
                    state_next.high_nibble       = dval;
                    state_next.first_digit_valid = hd.is_digit;
                end
            end
            urlpd_pkg::PH_SECOND:
            begin
                if (!state.first_digit_valid)
                    result.out_byte = 8'd0;
                else if (hd.is_digit)
                    result.out_byte = {state.high_nibble, hd.value};
                else
                    result.out_byte = {4'd0, state.high_nibble};
            end
            urlpd_pkg::PH_IDLE, urlpd_pkg::PH_RESERVED:
            begin
                if (item.in_byte == urlpd_pkg::PERCENT_CHAR)
                begin
                    result.out_byte = 8'd0;
                    if (!item.in_last)
                    begin
                        emit                    = 1'b0;
                        state_next.escape_phase = urlpd_pkg::PH_FIRST;
                    end
                end
            end
            default:
            begin
                result.out_byte = item.in_byte;
            end
        endcase
    end

endmodule

// File: hw/rtl/url_percent_decoder.sv
// URL percent decoder top level: input register, escape decode, result register.
//
// Usage: encoded characters arrive on the enc channel (enc_valid, enc_stall,
// enc_data) with in_last set on the final character of a string. Decoded
// characters leave on the dec channel (dec_valid, dec_stall, dec_data).
// A transaction completes on a rising edge with valid high and stall low.
// Ordinary characters pass through; '%' and the next two characters form an
// escape that yields one decoded byte, or a partial value if in_last ends it.
// The '%' and first digit transactions of a full escape give no output.
// A result passes through the input register, then the result register, before
// it is presented. Throughput: one character per cycle while dec_stall is low,
// set by the combinational escape decode between the two registers.
// When dec_stall is high the result register holds; the input register then
// fills and enc_stall rises in the same cycle it can no longer drain.
// Reset clears both valid flags and returns the decoder outside any escape.
module url_percent_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enc_valid,
    output logic                 enc_stall,
    input  urlpd_pkg::in_item_t  enc_data,
    output logic                 dec_valid,
    input  logic                 dec_stall,
    output urlpd_pkg::out_item_t dec_data
);

    logic                  in_valid_reg;
    urlpd_pkg::in_item_t   in_item_reg;
    urlpd_pkg::esc_state_t state_reg;
    urlpd_pkg::esc_state_t state_next;
    logic                  out_valid_reg;
    urlpd_pkg::out_item_t  out_item_reg;
    logic                  emit;
    urlpd_pkg::out_item_t  result;
    logic                  out_free;
    logic                  advance;

    assign out_free  = !out_valid_reg || !dec_stall;
    assign advance   = in_valid_reg && out_free;
    assign enc_stall = in_valid_reg && !out_free;

    urlpd_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (enc_valid && !enc_stall)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= emit;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enc_valid && !enc_stall)
            in_item_reg <= enc_data;
        if (advance && emit)
            out_item_reg <= result;
    end

    assign dec_valid = out_valid_reg;
    assign dec_data  = out_item_reg;

    a_no_reserved_phase: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg.escape_phase != urlpd_pkg::PH_RESERVED
    ) else $error("escape phase reached unused code");

    a_last_ends_escape: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.in_last |=> state_reg.escape_phase == urlpd_pkg::PH_IDLE
    ) else $error("end of string left decoder inside an escape");

    a_idle_state_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg.escape_phase != urlpd_pkg::PH_SECOND
            |-> state_reg.high_nibble == 4'd0 && !state_reg.first_digit_valid
    ) else $error("stale nibble outside second digit phase");

    a_last_always_emits: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.in_last |=> out_valid_reg && out_item_reg.out_last
    ) else $error("final character produced no result");

endmodule
